// File: rtl/pmlu_pkg.sv
package pmlu_pkg;

  // field widths
  localparam int SPIN_W    = 3;
  localparam int SITE_W    = 10;
  localparam int DRAW_W    = 16;
  localparam int NSTATE_W  = 4;
  localparam int ENERGY_W  = 13;
  localparam int MAG_W     = 14;
  localparam int CFG_IDX_W = 3;

  // fixed-point reciprocal for the site modulo
  localparam int RECIP_SHIFT = 20;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RED,
    ST_READ,
    ST_EVAL
  } state_t;

  localparam logic OP_WRITE       = 1'b0;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE4    = 3'd4;

  localparam logic [NSTATE_W-1:0] NUM_STATES_RST = 4'd2;
  localparam logic [DRAW_W-1:0]   THR_DE1_RST    = 16'd26403;
  localparam logic [DRAW_W-1:0]   THR_DE2_RST    = 16'd10638;
  localparam logic [DRAW_W-1:0]   THR_DE3_RST    = 16'd4286;
  localparam logic [DRAW_W-1:0]   THR_DE4_RST    = 16'd1727;

  // read slots: the site, then right, left, down, up neighbours
  localparam logic [2:0] SLOT_SITE  = 3'd0;
  localparam logic [2:0] SLOT_RIGHT = 3'd1;
  localparam logic [2:0] SLOT_LEFT  = 3'd2;
  localparam logic [2:0] SLOT_DOWN  = 3'd3;
  localparam logic [2:0] SLOT_UP    = 3'd4;
  localparam logic [2:0] SLOT_LAST  = 3'd5;

endpackage

// File: rtl/pmlu_lattice_ram.sv
module pmlu_lattice_ram
  import pmlu_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [SPIN_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [SPIN_W-1:0] rdata
);

  logic [SPIN_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/potts_metropolis_lattice_update.sv
// Sequence: a request is taken in IDLE, the site modulo runs in DIV and RED, five serial
// reads go through the RAM's one read port in READ, and EVAL evaluates and writes back; the
// result strobe is registered from EVAL. A new request is taken only once the last is done.
// Reset (rst_n low, synchronous): totals, configuration and sequencer return to their defaults,
// then a clearing pass zeroes all SIDE*SIDE sites of the lattice (1024 by default) with
// busy high. Configuration is taken at any time; the receiver cannot stall results.
module potts_metropolis_lattice_update
  import pmlu_pkg::*;
#(
  parameter int SIDE       = 32,
  parameter int MAX_STATES = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic [SITE_W-1:0]          in_site,
  input  logic [SPIN_W-1:0]          in_spin_value,
  input  logic [DRAW_W-1:0]          in_uniform_draw,
  // result channel
  output logic                       out_valid,
  output logic                       out_accepted,
  output logic [SPIN_W-1:0]          out_spin_now,
  output logic signed [ENERGY_W-1:0] out_total_energy,
  output logic signed [MAG_W-1:0]    out_magnetization,
  output logic                       out_status,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [DRAW_W-1:0]          cfg_data
);

  localparam int N     = SIDE * SIDE;
  localparam int AW    = $clog2(N);
  localparam int RECIP = (1 << RECIP_SHIFT) / N;

  localparam logic [AW-1:0] IDX_LAST = AW'(N - 1);
  localparam logic [AW-1:0] SIDE_A   = AW'(SIDE);
  localparam logic [AW-1:0] UP_WRAP  = AW'(N - SIDE);
  localparam logic [AW:0]   N_X      = (AW + 1)'(N);

  localparam logic [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(-4 * N);
  localparam logic [MAG_W-1:0]    N_MAG      = MAG_W'(N);

  // ---------------------------------------------------------------------------
  // Configuration registers; the port never pushes back.
  // ---------------------------------------------------------------------------
  logic [NSTATE_W-1:0] num_states_r;
  logic [DRAW_W-1:0]   thr_de1_r, thr_de2_r, thr_de3_r, thr_de4_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r <= NUM_STATES_RST;
      thr_de1_r    <= THR_DE1_RST;
      thr_de2_r    <= THR_DE2_RST;
      thr_de3_r    <= THR_DE3_RST;
      thr_de4_r    <= THR_DE4_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_STATES: num_states_r <= cfg_data[NSTATE_W-1:0];
        REG_THR_DE1:    thr_de1_r    <= cfg_data;
        REG_THR_DE2:    thr_de2_r    <= cfg_data;
        REG_THR_DE3:    thr_de3_r    <= cfg_data;
        REG_THR_DE4:    thr_de4_r    <= cfg_data;
        default: ;  // index beyond the register list: no effect
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: CLEAR (after reset) -> IDLE -> DIV -> RED -> READ -> EVAL
  // ---------------------------------------------------------------------------
  state_t        state_r, state_nxt;
  logic [2:0]    rd_cnt_r, rd_cnt_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          take;

  assign busy = (state_r != ST_IDLE);
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      rd_cnt_r  <= SLOT_SITE;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rd_cnt_nxt  = rd_cnt_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: state_nxt = ST_RED;
      ST_RED: begin
        state_nxt  = ST_READ;
        rd_cnt_nxt = SLOT_SITE;
      end
      ST_READ: begin
        rd_cnt_nxt = rd_cnt_r + 3'd1;
        if (rd_cnt_r == SLOT_LAST) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request capture
  // ---------------------------------------------------------------------------
  logic              op_r;
  logic [SITE_W-1:0] site_r;
  logic [SPIN_W-1:0] value_r;
  logic [DRAW_W-1:0] draw_r;

  always_ff @(posedge clk) begin
    if (take) begin
      op_r    <= in_operation;
      site_r  <= in_site;
      value_r <= in_spin_value;
      draw_r  <= in_uniform_draw;
    end
  end

  // ---------------------------------------------------------------------------
  // Site modulo N: quotient estimate by reciprocal (DIV), then remainder with
  // one correcting subtract (RED). The estimate is never high and at most one low.
  // ---------------------------------------------------------------------------
  logic [31:0]       recip_prod, qn, rem_a, rem;
  logic [SITE_W-1:0] q_r;
  logic [AW-1:0]     site_idx_r;

  assign recip_prod = 32'(site_r) * 32'(RECIP);
  assign qn         = 32'(q_r) * 32'(N);
  assign rem_a      = 32'(site_r) - qn;
  assign rem        = (rem_a >= 32'(N)) ? rem_a - 32'(N) : rem_a;

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV) begin
      q_r <= recip_prod[RECIP_SHIFT+SITE_W-1:RECIP_SHIFT];
    end
    if (state_r == ST_RED) begin
      site_idx_r <= rem[AW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Helical neighbours: i+1, i-1, i+SIDE, i-SIDE, all modulo N
  // ---------------------------------------------------------------------------
  logic [AW-1:0] nb_right, nb_left, nb_down, nb_up;
  logic [AW:0]   dn_sum, dn_wrap;

  assign nb_right = (site_idx_r == IDX_LAST) ? '0 : site_idx_r + AW'(1);
  assign nb_left  = (site_idx_r == '0) ? IDX_LAST : site_idx_r - AW'(1);
  assign dn_sum   = {1'b0, site_idx_r} + {1'b0, SIDE_A};
  assign dn_wrap  = dn_sum - N_X;
  assign nb_down  = (dn_sum >= N_X) ? dn_wrap[AW-1:0] : dn_sum[AW-1:0];
  assign nb_up    = (site_idx_r >= SIDE_A) ? site_idx_r - SIDE_A : site_idx_r + UP_WRAP;

  // ---------------------------------------------------------------------------
  // Lattice RAM: one read and one write port; read data is registered, in the next cycle, not later
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [SPIN_W-1:0] ram_wdata, ram_rdata;
  logic              change;

  always_comb begin
    case (rd_cnt_r)
      SLOT_SITE:  ram_raddr = site_idx_r;
      SLOT_RIGHT: ram_raddr = nb_right;
      SLOT_LEFT:  ram_raddr = nb_left;
      SLOT_DOWN:  ram_raddr = nb_down;
      SLOT_UP:    ram_raddr = nb_up;
      default:    ram_raddr = site_idx_r;
    endcase
  end

  assign ram_we    = (state_r == ST_CLEAR) || ((state_r == ST_EVAL) && change);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : site_idx_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : value_r;

  pmlu_lattice_ram #(
    .DEPTH (N),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read data shifts in slot by slot; after five captures [4] holds the site
  // spin and [3:0] the right, left, down and up neighbours.
  logic [4:0][SPIN_W-1:0] spin_sh_r;

  always_ff @(posedge clk) begin
    if ((state_r == ST_READ) && (rd_cnt_r != SLOT_SITE)) begin
      spin_sh_r <= {spin_sh_r[3:0], ram_rdata};
    end
  end

  // ---------------------------------------------------------------------------
  // Evaluation: dE = (equal to old) - (equal to proposed), acceptance, totals
  // ---------------------------------------------------------------------------
  logic [SPIN_W-1:0]   old_spin;
  logic [2:0]          c_old, c_new;
  logic signed [3:0]   de;
  logic [DRAW_W-1:0]   thr_sel;
  logic                refused, accept;
  logic [3:0]          spin_diff;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [MAG_W-1:0]    sum_r, sum_nxt, mag;

  assign old_spin = spin_sh_r[4];

  always_comb begin
    c_old = '0;
    c_new = '0;
    for (int k = 0; k < 4; k++) begin
      c_old = c_old + 3'(spin_sh_r[k] == old_spin);
      c_new = c_new + 3'(spin_sh_r[k] == value_r);
    end
  end

  assign de = signed'({1'b0, c_old}) - signed'({1'b0, c_new});

  always_comb begin
    case (de)
      4'sd1:   thr_sel = thr_de1_r;
      4'sd2:   thr_sel = thr_de2_r;
      4'sd3:   thr_sel = thr_de3_r;
      4'sd4:   thr_sel = thr_de4_r;
      default: thr_sel = '0;
    endcase
  end

  assign refused = !({1'b0, value_r} < num_states_r) || !(32'(value_r) < 32'(MAX_STATES));
  assign accept  = !refused && ((op_r == OP_WRITE) || (value_r == old_spin) ||
                                (de <= 4'sd0) || (draw_r <= thr_sel));
  assign change  = accept && (value_r != old_spin);

  assign spin_diff  = {1'b0, value_r} - {1'b0, old_spin};
  assign energy_nxt = change ? energy_r + {{(ENERGY_W-5){de[3]}}, de, 1'b0} : energy_r;
  assign sum_nxt    = change ? sum_r + {{(MAG_W-4){spin_diff[3]}}, spin_diff} : sum_r;
  // two-state case reports 2*sum-N, otherwise the plain sum
  assign mag        = (num_states_r == NUM_STATES_RST) ?
                      {sum_nxt[MAG_W-2:0], 1'b0} - N_MAG : sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= ENERGY_RST;
      sum_r    <= '0;
    end else if (state_r == ST_EVAL) begin
      energy_r <= energy_nxt;
      sum_r    <= sum_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: one-cycle strobe, payload held without reset
  // ---------------------------------------------------------------------------
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EVAL) begin
      out_accepted      <= accept;
      out_spin_now      <= change ? value_r : old_spin;
      out_total_energy  <= signed'(energy_nxt);
      out_magnetization <= signed'(mag);
      out_status        <= refused ? STATUS_REFUSED : STATUS_OK;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_strobe_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EVAL))
    else $error("result strobe without evaluation");

  a_take_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (state_r == ST_DIV))
    else $error("accepted request did not start the sequence");

  a_refused_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_REFUSED)) |-> !out_accepted)
    else $error("refused request reported as accepted");

  a_totals_only_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_EVAL) |=> ($stable(energy_r) && $stable(sum_r)))
    else $error("totals changed outside evaluation");

  a_no_write_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_CLEAR) || (state_r == ST_EVAL)))
    else $error("lattice write outside clear or evaluation");

endmodule
